// ----- rtl/apq_pkg.sv -----
// Shared types and constants of the array priority queue.
// Used by array_priority_queue, apq_minscan and the testbench; depends on nothing.
package apq_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 2 * DATA_W;

   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_LOCATE = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_FINISH = 5'b10000
   } apq_state_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } apq_cmp_type;

endpackage

// ----- rtl/array_priority_queue.sv -----
// Min-priority queue kept as an unsorted array in arrival order.
// Request word: req_type (append, delete, peek, clear), req_item_value and
// req_item_priority. Result word: rsp_status, rsp_out_value, rsp_out_priority
// and rsp_out_count. Every request gives exactly one result.
// A request is taken when req_valid is high and req_stall low; req_stall is
// low only while the sequencer is idle. A result is held on the rsp_ ports
// while rsp_stall is high, and the next request may be taken meanwhile.
// Append, clear and requests on an empty queue go straight to the result
// stage; peek first runs a search pass; delete adds a shift pass after it.
// All entries sit in one RAM with a single read port, so the minimum search
// reads one entry a cycle and the shift after a delete moves one entry a
// cycle. A new request is taken only after the last one's result is loaded.
// Reset empties the queue and drops any pending result; the RAM is not
// cleared, since only entries below the count are ever read.
// Depends on apq_pkg, apq_ram and apq_minscan.
module array_priority_queue import apq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [REQ_W-1:0]         req_type,
   input  logic signed [DATA_W-1:0] req_item_value,
   input  logic signed [DATA_W-1:0] req_item_priority,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [DATA_W-1:0] rsp_out_value,
   output logic signed [DATA_W-1:0] rsp_out_priority,
   output logic [CNT_W-1:0]         rsp_out_count
);

   apq_state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [REQ_W-1:0]    op_ff, op_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                use_best_ff, use_best_in;
   apq_cmp_type         cmp_ff, cmp_in;
   logic                shw_valid_ff, shw_valid_in;
   logic [IDX_W-1:0]    shw_idx_ff, shw_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_prio_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [ENTRY_W-1:0]  rd_data;
   logic                issue;
   logic                load;
   logic [IDX_W-1:0]    best_idx;
   logic signed [DATA_W-1:0] best_value, best_prio;

   apq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   apq_minscan u_minscan (
      .clock      (clock),
      .cmp        (cmp_ff),
      .rd_value   ($signed(rd_data[ENTRY_W-1:DATA_W])),
      .rd_prio    ($signed(rd_data[DATA_W-1:0])),
      .best_idx   (best_idx),
      .best_value (best_value),
      .best_prio  (best_prio)
   );

   assign issue = ptr_ff < count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      use_best_in  = use_best_ff;
      cmp_in       = '0;
      shw_valid_in = 1'b0;
      shw_idx_in   = shw_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = {req_item_value, req_item_priority};
      load         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_type;
               status_in   = ST_OK;
               use_best_in = 1'b0;
               ptr_in      = '0;
               state_in    = S_FINISH;
               case (req_type)
                  REQ_APPEND: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_DELETE, REQ_PEEK: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        use_best_in = 1'b1;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               cmp_in.valid = 1'b1;
               cmp_in.idx   = ptr_ff[IDX_W-1:0];
               ptr_in       = ptr_ff + CNT_W'(1);
            end
            if (cmp_ff.valid && (CNT_W'(cmp_ff.idx) == count_ff - CNT_W'(1))) begin
               state_in = (op_ff == REQ_DELETE) ? S_LOCATE : S_FINISH;
            end
         end
         S_LOCATE: begin
            ptr_in   = CNT_W'(best_idx) + CNT_W'(1);
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (issue) begin
               shw_valid_in = 1'b1;
               shw_idx_in   = ptr_ff[IDX_W-1:0] - IDX_W'(1);
               ptr_in       = ptr_ff + CNT_W'(1);
            end
            if (shw_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = shw_idx_ff;
               wr_data = rd_data;
            end
            if (!issue && !shw_valid_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_ff       <= '0;
         shw_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_ff       <= cmp_in;
         shw_valid_ff <= shw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      op_ff       <= op_in;
      status_ff   <= status_in;
      use_best_ff <= use_best_in;
      shw_idx_ff  <= shw_idx_in;
      if (load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= use_best_ff ? best_value : '0;
         rsp_prio_ff   <= use_best_ff ? best_prio : '0;
         rsp_count_ff  <= count_ff;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_out_count    = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("Entry count exceeds the capacity.");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_ff.valid |-> state_ff == S_SCAN)
      else $error("Compare unit fed outside the search pass.");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> rsp_count_ff == '0)
      else $error("Empty status reported with entries present.");
`endif

endmodule

// ----- rtl/apq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module apq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/apq_minscan.sv -----
// Shared signed compare unit that tracks the earliest entry with the smallest priority.
// Depends on apq_pkg.
module apq_minscan import apq_pkg::*; (
   input  logic                     clock,
   input  apq_cmp_type              cmp,
   input  logic signed [DATA_W-1:0] rd_value,
   input  logic signed [DATA_W-1:0] rd_prio,
   output logic [IDX_W-1:0]         best_idx,
   output logic signed [DATA_W-1:0] best_value,
   output logic signed [DATA_W-1:0] best_prio
);

   logic [IDX_W-1:0]         best_idx_ff;
   logic signed [DATA_W-1:0] best_value_ff;
   logic signed [DATA_W-1:0] best_prio_ff;
   logic                     take;

   // A strict compare keeps the earliest entry on a tie.
   assign take = cmp.valid && ((cmp.idx == '0) || (rd_prio < best_prio_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff   <= cmp.idx;
         best_value_ff <= rd_value;
         best_prio_ff  <= rd_prio;
      end
   end

   assign best_idx   = best_idx_ff;
   assign best_value = best_value_ff;
   assign best_prio  = best_prio_ff;

endmodule

// ----- tb/sv/array_priority_queue_tb.sv -----
`timescale 1ns / 100ps
// Testbench for array_priority_queue: a directed opening and random request phases,
// with results checked against a mirrored copy of the queue kept in a scoreboard class.
// Depends on apq_pkg and the array_priority_queue RTL.
module array_priority_queue_tb;
   import apq_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1800;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 60;
   localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] WORD_MAX = ~WORD_MIN;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
      logic [CNT_W-1:0]         count;
   } outcome_type;

   class queue_scoreboard_type;
      logic signed [DATA_W-1:0] mirror_value[CAPACITY];
      logic signed [DATA_W-1:0] mirror_prio[CAPACITY];
      int                       mirror_count;
      outcome_type              awaited[$];
      int                       failures;

      function void note_request(logic [REQ_W-1:0] kind, logic signed [DATA_W-1:0] value,
                                 logic signed [DATA_W-1:0] prio);
         outcome_type want;
         int best;
         want = '0;
         want.status = ST_OK;
         case (kind)
            REQ_APPEND: begin
               if (mirror_count == CAPACITY) begin
                  want.status = ST_FULL;
               end else begin
                  mirror_value[mirror_count] = value;
                  mirror_prio[mirror_count] = prio;
                  mirror_count++;
               end
            end
            REQ_DELETE, REQ_PEEK: begin
               if (mirror_count == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  best = 0;
                  for (int k = 1; k < mirror_count; k++) begin
                     if (mirror_prio[k] < mirror_prio[best]) best = k;
                  end
                  want.value = mirror_value[best];
                  want.prio = mirror_prio[best];
                  if (kind == REQ_DELETE) begin
                     for (int k = best; k < mirror_count - 1; k++) begin
                        mirror_value[k] = mirror_value[k + 1];
                        mirror_prio[k] = mirror_prio[k + 1];
                     end
                     mirror_count--;
                  end
               end
            end
            default: begin
               mirror_count = 0;
            end
         endcase
         want.count = CNT_W'(mirror_count);
         awaited.push_back(want);
      endfunction

      function void check_response(outcome_type got);
         outcome_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response with nothing outstanding: status=%0d value=%0d",
                     $time, got.status, got.value);
            $display("%0t: priority=%0d count=%0d", $time, got.prio, got.count);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            $display("%0t: expected status=%0d value=%0d priority=%0d count=%0d", $time,
                     want.status, want.value, want.prio, want.count);
            $display("%0t: actual   status=%0d value=%0d priority=%0d count=%0d", $time,
                     got.status, got.value, got.prio, got.count);
            failures++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [REQ_W-1:0]         req_type = REQ_APPEND;
   logic signed [DATA_W-1:0] req_item_value = '0;
   logic signed [DATA_W-1:0] req_item_priority = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic signed [DATA_W-1:0] rsp_out_priority;
   logic [CNT_W-1:0]         rsp_out_count;

   queue_scoreboard_type board = new();
   logic steady_sender = 1'b0;
   logic steady_receiver = 1'b0;
   logic long_hold_pending = 1'b0;
   int   quiet_cycles = 0;

   array_priority_queue dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic send_request(logic [REQ_W-1:0] kind, logic signed [DATA_W-1:0] value,
                               logic signed [DATA_W-1:0] prio);
      int gap;
      gap = steady_sender ? 0 : $urandom_range(10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_item_value <= value;
      req_item_priority <= prio;
      do @(posedge clock); while (req_stall);
      board.note_request(kind, value, prio);
   endtask

   task automatic await_all_answered();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic logic [REQ_W-1:0] draw_kind(mix_type mix);
      int roll;
      int append_below;
      int delete_below;
      int peek_below;
      case (mix)
         MIX_FILL: begin
            append_below = 75; delete_below = 87; peek_below = 98;
         end
         MIX_DRAIN: begin
            append_below = 20; delete_below = 75; peek_below = 95;
         end
         default: begin
            append_below = 45; delete_below = 75; peek_below = 96;
         end
      endcase
      roll = $urandom_range(99);
      if (roll < append_below) return REQ_APPEND;
      if (roll < delete_below) return REQ_DELETE;
      if (roll < peek_below) return REQ_PEEK;
      return REQ_CLEAR;
   endfunction

   function automatic logic signed [DATA_W-1:0] draw_priority();
      case ($urandom_range(2))
         0: return $urandom;
         1: return $urandom_range(6) - 3;
         default: begin
            case ($urandom_range(3))
               0: return WORD_MIN;
               1: return WORD_MAX;
               2: return '1;
               default: return '0;
            endcase
         end
      endcase
   endfunction

   initial begin : response_side
      int hold;
      outcome_type got;
      wait (reset == 1'b0);
      forever begin
         if (long_hold_pending) begin
            hold = LONG_HOLD;
            long_hold_pending = 1'b0;
         end else begin
            hold = steady_receiver ? 0 : $urandom_range(10);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.status = rsp_status;
         got.value = rsp_out_value;
         got.prio = rsp_out_priority;
         got.count = rsp_out_count;
         board.check_response(got);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
         $display("array_priority_queue_tb: FAIL");
         $finish;
      end
   end

   initial begin : request_side
      int sent;
      int phase;
      int span;
      mix_type mix;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_request(REQ_DELETE, $urandom, $urandom);
      send_request(REQ_PEEK, $urandom, $urandom);
      send_request(REQ_APPEND, WORD_MIN, WORD_MAX);
      send_request(REQ_APPEND, WORD_MAX, WORD_MIN);
      send_request(REQ_APPEND, '1, WORD_MIN);
      send_request(REQ_APPEND, '0, '1);
      repeat (12) send_request(REQ_APPEND, $urandom, draw_priority());
      send_request(REQ_APPEND, $urandom, $urandom);
      send_request(REQ_PEEK, $urandom, $urandom);
      send_request(REQ_DELETE, $urandom, $urandom);
      send_request(REQ_DELETE, $urandom, $urandom);
      send_request(REQ_CLEAR, $urandom, $urandom);
      send_request(REQ_PEEK, $urandom, $urandom);

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         mix = mix_type'($urandom_range(2));
         steady_sender = ($urandom_range(3) == 0);
         steady_receiver = ($urandom_range(3) == 0);
         if (phase == 2) long_hold_pending = 1'b1;
         span = $urandom_range(20, 80);
         repeat (span) begin
            send_request(draw_kind(mix), $urandom, draw_priority());
            sent++;
         end
         if (phase == 5 || $urandom_range(3) == 0) await_all_answered();
         phase++;
      end

      await_all_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0) begin
         $display("array_priority_queue_tb: PASS");
      end else begin
         $display("array_priority_queue_tb: FAIL");
      end
      $finish;
   end

endmodule
